/* hdl/ldr_pkg.sv */
// Package for the lens distortion remap pipeline.
// Holds the field widths, payload and stage-boundary structs, and the
// configuration register map. Depends on nothing.
package ldr_pkg;

  // Destination bounds.
  localparam int MAX_DIM   = 4096;
  localparam int FIELD_CAP = 4096;
  localparam int DIM_BOUND = (MAX_DIM < FIELD_CAP) ? MAX_DIM : FIELD_CAP;

  // Field widths.
  localparam int DIM_W   = 13;
  localparam int COORD_W = 12;
  localparam int PIX_W   = 8;
  localparam int COEF_W  = 32;

  // Internal datapath widths.
  localparam int D_W    = COORD_W + 1;        // centered coordinate, signed
  localparam int SQ_W   = 2 * COORD_W;        // dx*dx
  localparam int XY_W   = SQ_W + 1;           // dx*dy, signed
  localparam int R2_W   = SQ_W + 1;           // dx*dx + dy*dy
  localparam int CR_W   = XY_W + 1;           // 2*dx*dy, signed
  localparam int ASQ_W  = R2_W + 2;           // r2 + 2*d*d
  localparam int R4_W   = 2 * R2_W;           // r2*r2
  localparam int R4L_W  = R2_W;               // low slice of r4
  localparam int DK_W   = COEF_W + D_W;       // d*k, signed
  localparam int PKL_W  = COEF_W + R2_W;      // unsigned partial product
  localparam int PKH_W  = D_W + R2_W + 1;     // signed partial product
  localparam int TP_W   = COEF_W + ASQ_W + 1; // tangential product, signed
  localparam int TS_W   = TP_W + 1;           // tangential sum, signed
  localparam int K1T_W  = PKH_W + COEF_W;     // d*k1*r2, signed
  localparam int FRAC_W = 80;                 // fraction bits of the accumulator
  localparam int ACC_W  = 106;
  localparam int INT_W  = ACC_W - FRAC_W;
  localparam int K1_SH  = 32;                 // k1 term alignment
  localparam int TANG_SH = 40;                // tangential term alignment

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_CENTER_X     = 3'd2,
    REG_CENTER_Y     = 3'd3,
    REG_RADIAL_K1    = 3'd4,
    REG_RADIAL_K2    = 3'd5,
    REG_TANGENT_P1   = 3'd6,
    REG_TANGENT_P2   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic        [DIM_W-1:0]   image_width;
    logic        [DIM_W-1:0]   image_height;
    logic        [COORD_W-1:0] center_x;
    logic        [COORD_W-1:0] center_y;
    logic signed [COEF_W-1:0]  radial_k1;
    logic signed [COEF_W-1:0]  radial_k2;
    logic signed [COEF_W-1:0]  tangent_p1;
    logic signed [COEF_W-1:0]  tangent_p2;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    image_width:  13'd640,
    image_height: 13'd480,
    center_x:     12'd320,
    center_y:     12'd240,
    radial_k1:    32'sd0,
    radial_k2:    32'sd0,
    tangent_p1:   32'sd0,
    tangent_p2:   32'sd0
  };

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [PIX_W-1:0]   pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic [PIX_W-1:0]   pixel_out;
    logic               in_range;
  } out_item_t;

  // Front end to multiplier stages. Index 0 is the x axis, 1 the y axis.
  typedef struct packed {
    logic [1:0][COORD_W-1:0] src;
    logic [PIX_W-1:0]        pix;
    logic [R2_W-1:0]         r2;
    logic [CR_W-1:0]         cross2;
    logic [1:0][ASQ_W-1:0]   asq;
    logic [1:0][DK_W-1:0]    dk1;
    logic [1:0][DK_W-1:0]    dk2;
  } front_t;

  // Per-axis partial products handed to the accumulator.
  typedef struct packed {
    logic [PKL_W-1:0] ll;
    logic [PKL_W-1:0] lh;
    logic [PKH_W-1:0] hl;
    logic [PKH_W-1:0] hh;
    logic [K1T_W-1:0] k1t;
    logic [TS_W-1:0]  tang;
  } axis_prod_t;

  typedef struct packed {
    logic [1:0][COORD_W-1:0] src;
    logic [PIX_W-1:0]        pix;
    axis_prod_t [1:0]        ax;
  } mult_t;

endpackage

/* hdl/ldr_front.sv */
// Front end of the remap pipeline: centering, squares and d*k products.
// Three register stages. Depends on ldr_pkg.
module ldr_front
  import ldr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_item,
  input  cfg_t     cfg,
  output logic     front_valid,
  output front_t   front
);

  logic [COORD_W-1:0]          src_in [2];
  logic [COORD_W-1:0]          ctr    [2];
  logic signed [D_W-1:0]       d_nxt  [2];

  logic                        v1_r;
  logic signed [D_W-1:0]       d1_r   [2];
  logic [1:0][COORD_W-1:0]     src1_r;
  logic [PIX_W-1:0]            pix1_r;

  logic signed [2*D_W-1:0]     sq_full [2];
  logic signed [2*D_W-1:0]     xy_full;
  logic [1:0][DK_W-1:0]        dk1_nxt;
  logic [1:0][DK_W-1:0]        dk2_nxt;

  logic                        v2_r;
  logic [1:0][SQ_W-1:0]        sq2_r;
  logic [XY_W-1:0]             xy2_r;
  logic [1:0][DK_W-1:0]        dk1_2_r;
  logic [1:0][DK_W-1:0]        dk2_2_r;
  logic [1:0][COORD_W-1:0]     src2_r;
  logic [PIX_W-1:0]            pix2_r;

  logic [R2_W-1:0]             r2_s;
  front_t                      front_nxt;
  logic                        v3_r;
  front_t                      front_r;

  assign src_in[0] = in_item.src_x;
  assign src_in[1] = in_item.src_y;
  assign ctr[0]    = cfg.center_x;
  assign ctr[1]    = cfg.center_y;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      d_nxt[i] = $signed({1'b0, src_in[i]}) - $signed({1'b0, ctr[i]});
    end
  end

  // Stage 1: centered coordinates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    d1_r[0]   <= d_nxt[0];
    d1_r[1]   <= d_nxt[1];
    src1_r[0] <= in_item.src_x;
    src1_r[1] <= in_item.src_y;
    pix1_r    <= in_item.pixel_value;
  end

  // Stage 2: squares, cross product and coordinate times radial coefficients.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sq_full[i] = (2*D_W)'(d1_r[i]) * (2*D_W)'(d1_r[i]);
      dk1_nxt[i] = DK_W'(d1_r[i]) * DK_W'($signed(cfg.radial_k1));
      dk2_nxt[i] = DK_W'(d1_r[i]) * DK_W'($signed(cfg.radial_k2));
    end
    xy_full = (2*D_W)'(d1_r[0]) * (2*D_W)'(d1_r[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sq2_r[0] <= sq_full[0][SQ_W-1:0];
    sq2_r[1] <= sq_full[1][SQ_W-1:0];
    xy2_r    <= xy_full[XY_W-1:0];
    dk1_2_r  <= dk1_nxt;
    dk2_2_r  <= dk2_nxt;
    src2_r   <= src1_r;
    pix2_r   <= pix1_r;
  end

  // Stage 3: radius squared and the two tangential sums of squares.
  assign r2_s = R2_W'(sq2_r[0]) + R2_W'(sq2_r[1]);

  always_comb begin
    front_nxt.src    = src2_r;
    front_nxt.pix    = pix2_r;
    front_nxt.r2     = r2_s;
    front_nxt.cross2 = {xy2_r, 1'b0};
    front_nxt.asq[0] = ASQ_W'(r2_s) + ASQ_W'({sq2_r[0], 1'b0});
    front_nxt.asq[1] = ASQ_W'(r2_s) + ASQ_W'({sq2_r[1], 1'b0});
    front_nxt.dk1    = dk1_2_r;
    front_nxt.dk2    = dk2_2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    front_r <= front_nxt;
  end

  assign front_valid = v3_r;
  assign front       = front_r;

endmodule

/* hdl/ldr_mult.sv */
// Multiplier stages of the remap pipeline: r^4, tangential products and the
// wide radial products split into 32-bit partials. Depends on ldr_pkg.
module ldr_mult
  import ldr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   front_valid,
  input  front_t front,
  input  cfg_t   cfg,
  output logic   mult_valid,
  output mult_t  mult
);

  logic [R4_W-1:0]            r4_nxt;
  logic [1:0][1:0][TP_W-1:0]  tp_nxt;
  logic [1:0][PKL_W-1:0]      pk1l_nxt;
  logic [1:0][PKH_W-1:0]      pk1h_nxt;

  logic                       v4_r;
  logic [R4_W-1:0]            r4_4_r;
  logic [1:0][1:0][TP_W-1:0]  tp4_r;
  logic [1:0][PKL_W-1:0]      pk1l4_r;
  logic [1:0][PKH_W-1:0]      pk1h4_r;
  logic [1:0][DK_W-1:0]       dk2_4_r;
  logic [1:0][COORD_W-1:0]    src4_r;
  logic [PIX_W-1:0]           pix4_r;

  logic [R4L_W-1:0]           r4_lo;
  logic [R4_W-R4L_W-1:0]      r4_hi;
  mult_t                      mult_nxt;
  logic                       v5_r;
  mult_t                      mult_r;

  // Stage 4. The d*k1 product is split into a signed upper slice and an
  // unsigned lower 32-bit slice so each multiplier stays within 32 bits.
  always_comb begin
    r4_nxt       = R4_W'(front.r2) * R4_W'(front.r2);
    tp_nxt[0][0] = TP_W'($signed(cfg.tangent_p1)) * TP_W'($signed(front.cross2));
    tp_nxt[0][1] = TP_W'($signed(cfg.tangent_p2)) * TP_W'($signed({1'b0, front.asq[0]}));
    tp_nxt[1][0] = TP_W'($signed(cfg.tangent_p1)) * TP_W'($signed({1'b0, front.asq[1]}));
    tp_nxt[1][1] = TP_W'($signed(cfg.tangent_p2)) * TP_W'($signed(front.cross2));
    for (int i = 0; i < 2; i++) begin
      pk1l_nxt[i] = PKL_W'(front.dk1[i][COEF_W-1:0]) * PKL_W'(front.r2);
      pk1h_nxt[i] = PKH_W'($signed(front.dk1[i][DK_W-1:COEF_W]))
                  * PKH_W'($signed({1'b0, front.r2}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= front_valid;
    end
  end

  always_ff @(posedge clk) begin
    r4_4_r  <= r4_nxt;
    tp4_r   <= tp_nxt;
    pk1l4_r <= pk1l_nxt;
    pk1h4_r <= pk1h_nxt;
    dk2_4_r <= front.dk2;
    src4_r  <= front.src;
    pix4_r  <= front.pix;
  end

  // Stage 5: four partials of d*k2*r4 per axis, and the k1 and tangential
  // terms folded together.
  assign r4_lo = r4_4_r[R4L_W-1:0];
  assign r4_hi = r4_4_r[R4_W-1:R4L_W];

  always_comb begin
    mult_nxt.src = src4_r;
    mult_nxt.pix = pix4_r;
    for (int i = 0; i < 2; i++) begin
      mult_nxt.ax[i].ll = PKL_W'(dk2_4_r[i][COEF_W-1:0]) * PKL_W'(r4_lo);
      mult_nxt.ax[i].lh = PKL_W'(dk2_4_r[i][COEF_W-1:0]) * PKL_W'(r4_hi);
      mult_nxt.ax[i].hl = PKH_W'($signed(dk2_4_r[i][DK_W-1:COEF_W]))
                        * PKH_W'($signed({1'b0, r4_lo}));
      mult_nxt.ax[i].hh = PKH_W'($signed(dk2_4_r[i][DK_W-1:COEF_W]))
                        * PKH_W'($signed({1'b0, r4_hi}));
      mult_nxt.ax[i].k1t = (K1T_W'($signed(pk1h4_r[i])) << COEF_W)
                         + K1T_W'(pk1l4_r[i]);
      mult_nxt.ax[i].tang = TS_W'($signed(tp4_r[i][0])) + TS_W'($signed(tp4_r[i][1]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    mult_r <= mult_nxt;
  end

  assign mult_valid = v5_r;
  assign mult       = mult_r;

endmodule

/* hdl/ldr_acc.sv */
// Accumulator stages of the remap pipeline: sums the aligned terms, truncates
// toward zero and checks the image bounds. Depends on ldr_pkg.
module ldr_acc
  import ldr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      mult_valid,
  input  mult_t     mult,
  input  cfg_t      cfg,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam logic [DIM_W-1:0] BOUND_CAP = DIM_W'(DIM_BOUND);

  logic [1:0][ACC_W-1:0]   k2t_nxt;
  logic [1:0][ACC_W-1:0]   part_nxt;

  logic                    v6_r;
  logic [1:0][ACC_W-1:0]   k2t6_r;
  logic [1:0][ACC_W-1:0]   part6_r;
  logic [PIX_W-1:0]        pix6_r;

  logic                    v7_r;
  logic [1:0][ACC_W-1:0]   acc7_r;
  logic [PIX_W-1:0]        pix7_r;

  logic [DIM_W-1:0]        dim    [2];
  logic [DIM_W-1:0]        bound  [2];
  logic [1:0][INT_W-1:0]   coord;
  logic [1:0]              in_img;
  logic                    ok;
  out_item_t               out_nxt;

  logic                    out_valid_r;
  out_item_t               out_r;

  // Stage 6: fourth-order term and the remaining aligned terms.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      k2t_nxt[i] = ACC_W'(mult.ax[i].ll)
                 + (ACC_W'(mult.ax[i].lh) << R4L_W)
                 + (ACC_W'($signed(mult.ax[i].hl)) << COEF_W)
                 + (ACC_W'($signed(mult.ax[i].hh)) << (COEF_W + R4L_W));
      part_nxt[i] = (ACC_W'(mult.src[i]) << FRAC_W)
                  + (ACC_W'($signed(mult.ax[i].k1t)) << K1_SH)
                  + (ACC_W'($signed(mult.ax[i].tang)) << TANG_SH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= mult_valid;
    end
  end

  always_ff @(posedge clk) begin
    k2t6_r  <= k2t_nxt;
    part6_r <= part_nxt;
    pix6_r  <= mult.pix;
  end

  // Stage 7: full sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    acc7_r[0] <= part6_r[0] + k2t6_r[0];
    acc7_r[1] <= part6_r[1] + k2t6_r[1];
    pix7_r    <= pix6_r;
  end

  // Stage 8: the integer part is a floor, so a negative sum with a nonzero
  // fraction is bumped by one to truncate toward zero.
  assign dim[0] = cfg.image_width;
  assign dim[1] = cfg.image_height;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      bound[i]  = (dim[i] > BOUND_CAP) ? BOUND_CAP : dim[i];
      coord[i]  = acc7_r[i][ACC_W-1:FRAC_W]
                + INT_W'(acc7_r[i][ACC_W-1] & (|acc7_r[i][FRAC_W-1:0]));
      in_img[i] = !coord[i][INT_W-1] && (coord[i] < INT_W'(bound[i]));
    end
    ok = &in_img;
    out_nxt.dest_x    = ok ? coord[0][COORD_W-1:0] : '0;
    out_nxt.dest_y    = ok ? coord[1][COORD_W-1:0] : '0;
    out_nxt.pixel_out = pix7_r;
    out_nxt.in_range  = ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

/* hdl/lens_distortion_pixel_remap_top.sv */
// Top level of the Brown-Conrady lens distortion pixel remap.
// Holds the configuration registers and chains ldr_front, ldr_mult, ldr_acc.
// Depends on ldr_pkg.
//
//   Channel   Handshake              Payload
//   request   start / busy           in_data   (src_x, src_y, pixel_value)
//   result    out_valid (strobe)     out_data  (dest_x, dest_y, pixel_out, in_range)
//   config    cfg_we                 cfg_idx, cfg_data
//
// One request is taken every clock; busy is always low. Each result passes
// through the eight register stages of the datapath (centering, squares,
// radius and sums of squares, r^4 and tangential products, radial partial
// products, two accumulate stages, truncation and bounds check).
// Reset is synchronous and active low; it empties the pipeline and loads the
// register defaults. The result side has no back-pressure, so nothing stalls.
module lens_distortion_pixel_remap_top
  import ldr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [COEF_W-1:0]    cfg_data
);

  cfg_t    cfg_r;
  logic    front_valid;
  front_t  front;
  logic    mult_valid;
  mult_t   mult;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data[DIM_W-1:0];
        REG_CENTER_X:     cfg_r.center_x     <= cfg_data[COORD_W-1:0];
        REG_CENTER_Y:     cfg_r.center_y     <= cfg_data[COORD_W-1:0];
        REG_RADIAL_K1:    cfg_r.radial_k1    <= cfg_data;
        REG_RADIAL_K2:    cfg_r.radial_k2    <= cfg_data;
        REG_TANGENT_P1:   cfg_r.tangent_p1   <= cfg_data;
        REG_TANGENT_P2:   cfg_r.tangent_p2   <= cfg_data;
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  // The pipeline takes a request in every cycle.
  assign busy = 1'b0;

  ldr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (start & ~busy),
    .in_item     (in_data),
    .cfg         (cfg_r),
    .front_valid (front_valid),
    .front       (front)
  );

  ldr_mult u_mult (
    .clk         (clk),
    .rst_n       (rst_n),
    .front_valid (front_valid),
    .front       (front),
    .cfg         (cfg_r),
    .mult_valid  (mult_valid),
    .mult        (mult)
  );

  ldr_acc u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .mult_valid  (mult_valid),
    .mult        (mult),
    .cfg         (cfg_r),
    .out_valid   (out_valid),
    .out_item    (out_data)
  );

endmodule

/* verif/lens_distortion_pixel_remap_top_tb.sv */
// Self-checking testbench for lens_distortion_pixel_remap_top.
// Drives pixel requests and lens settings and checks each remapped pixel
// against an exact fixed-point predictor. Depends on ldr_pkg and the RTL.
module lens_distortion_pixel_remap_top_tb
  import ldr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY    = 8;
  localparam int IDLE_LIMIT = 1000;
  localparam int PHASES     = 6;
  localparam int PHASE_LEN  = 158;

  typedef struct {
    int        lens;
    in_item_t  px;
    bit        typed;
    out_item_t want;
  } probe_t;

  logic                 clk;
  logic                 rst_n    = 1'b0;
  logic                 start    = 1'b0;
  logic                 busy;
  in_item_t             in_data  = '0;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [COEF_W-1:0]    cfg_data = '0;

  // Typed expectation that travels alongside the request it belongs to.
  bit        want_typed = 1'b0;
  out_item_t want_item  = '0;

  cfg_t      lens_model = CFG_RESET;
  out_item_t remap_queue[$];
  int        idle_cycles     = 0;
  int        mismatches      = 0;
  int        checked_results = 0;
  int        inside_results  = 0;
  int        settings_loaded = 0;

  lens_distortion_pixel_remap_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // One axis of the remap, exact at 2^-80 and truncated toward zero.
  function automatic longint shift_axis(cfg_t c, logic [COORD_W-1:0] src, longint d,
                                        longint r2, longint tang);
    logic signed [127:0] acc, mag, w_r2, w_r4, w_dk1, w_dk2, w_tang;
    longint k1, k2, whole;
    k1     = longint'($signed(c.radial_k1));
    k2     = longint'($signed(c.radial_k2));
    w_r2   = 128'(r2);
    w_r4   = 128'(r2) * 128'(r2);
    w_dk1  = 128'(d) * 128'(k1);
    w_dk2  = 128'(d) * 128'(k2);
    w_tang = 128'(tang);
    acc = '0;
    acc[91:80] = src;
    acc = acc + ((w_dk1 * w_r2) <<< 32) + w_dk2 * w_r4 + (w_tang <<< 40);
    mag = (acc < 0) ? -acc : acc;
    whole = longint'(mag >> 80);
    return (acc < 0) ? -whole : whole;
  endfunction

  function automatic out_item_t remap_pixel(cfg_t c, in_item_t px);
    longint dx, dy, r2, cross2, p1, p2, tx, ty, dst_x, dst_y, bound_w, bound_h;
    out_item_t res;
    bit in_img;
    dx = longint'(px.src_x) - longint'(c.center_x);
    dy = longint'(px.src_y) - longint'(c.center_y);
    r2 = dx * dx + dy * dy;
    cross2 = 2 * dx * dy;
    p1 = longint'($signed(c.tangent_p1));
    p2 = longint'($signed(c.tangent_p2));
    tx = p1 * cross2 + p2 * (r2 + 2 * dx * dx);
    ty = p1 * (r2 + 2 * dy * dy) + p2 * cross2;
    dst_x = shift_axis(c, px.src_x, dx, r2, tx);
    dst_y = shift_axis(c, px.src_y, dy, r2, ty);
    bound_w = (c.image_width > DIM_BOUND) ? DIM_BOUND : longint'(c.image_width);
    bound_h = (c.image_height > DIM_BOUND) ? DIM_BOUND : longint'(c.image_height);
    in_img = dst_x >= 0 && dst_x < bound_w && dst_y >= 0 && dst_y < bound_h;
    res.dest_x    = in_img ? dst_x[COORD_W-1:0] : '0;
    res.dest_y    = in_img ? dst_y[COORD_W-1:0] : '0;
    res.pixel_out = px.pixel_value;
    res.in_range  = in_img;
    return res;
  endfunction

  function automatic cfg_t lens_write(cfg_t c, cfg_reg_t idx, logic [COEF_W-1:0] d);
    case (idx)
      REG_IMAGE_WIDTH:  c.image_width  = d[DIM_W-1:0];
      REG_IMAGE_HEIGHT: c.image_height = d[DIM_W-1:0];
      REG_CENTER_X:     c.center_x     = d[COORD_W-1:0];
      REG_CENTER_Y:     c.center_y     = d[COORD_W-1:0];
      REG_RADIAL_K1:    c.radial_k1    = d;
      REG_RADIAL_K2:    c.radial_k2    = d;
      REG_TANGENT_P1:   c.tangent_p1   = d;
      REG_TANGENT_P2:   c.tangent_p2   = d;
      default: ;
    endcase
    return c;
  endfunction

  function automatic cfg_t lens_of(int w, int h, int cx, int cy, logic [31:0] k1,
                                   logic [31:0] k2, logic [31:0] p1, logic [31:0] p2);
    cfg_t c;
    c.image_width  = DIM_W'(w);
    c.image_height = DIM_W'(h);
    c.center_x     = COORD_W'(cx);
    c.center_y     = COORD_W'(cy);
    c.radial_k1    = k1;
    c.radial_k2    = k2;
    c.tangent_p1   = p1;
    c.tangent_p2   = p2;
    return c;
  endfunction

  function automatic probe_t probe(int lens, int x, int y, int pix, bit typed,
                                   int ox, int oy, bit inr);
    probe_t p;
    p.lens           = lens;
    p.px.src_x       = COORD_W'(x);
    p.px.src_y       = COORD_W'(y);
    p.px.pixel_value = PIX_W'(pix);
    p.typed          = typed;
    p.want.dest_x    = COORD_W'(ox);
    p.want.dest_y    = COORD_W'(oy);
    p.want.pixel_out = PIX_W'(pix);
    p.want.in_range  = inr;
    return p;
  endfunction

  function automatic logic [31:0] rand_coef();
    logic [31:0] mag;
    case ($urandom_range(0, 11))
      0: return '0;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      default: begin
        mag = $urandom >> $urandom_range(8, 31);
        return ($urandom_range(0, 1) == 1) ? -mag : mag;
      end
    endcase
  endfunction

  function automatic int rand_dim();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return $urandom_range(4097, 8191);
      2: return 4096;
      3: return 1;
      default: return $urandom_range(16, 4096);
    endcase
  endfunction

  function automatic int pick_gap(bit no_idle);
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [COEF_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  // Sometimes put junk above the register width; the block must drop it.
  task automatic load_lens(cfg_t c);
    logic [31:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? $urandom : '0;
    write_reg(REG_IMAGE_WIDTH,  {junk[31:DIM_W], c.image_width});
    write_reg(REG_IMAGE_HEIGHT, {junk[31:DIM_W], c.image_height});
    write_reg(REG_CENTER_X,     {junk[31:COORD_W], c.center_x});
    write_reg(REG_CENTER_Y,     {junk[31:COORD_W], c.center_y});
    write_reg(REG_RADIAL_K1,    c.radial_k1);
    write_reg(REG_RADIAL_K2,    c.radial_k2);
    write_reg(REG_TANGENT_P1,   c.tangent_p1);
    write_reg(REG_TANGENT_P2,   c.tangent_p2);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  task automatic send_pixel(in_item_t px, bit typed, out_item_t want);
    start      <= 1'b1;
    in_data    <= px;
    want_typed <= typed;
    want_item  <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // The extra edge lets the request taken at this edge reach the queue first.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (remap_queue.size() != 0) @(posedge clk);
  endtask

  task automatic idle_after(int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : remap_check
    out_item_t want;
    bit active;
    active = 1'b0;
    if (!rst_n) begin
      lens_model = CFG_RESET;
    end else begin
      if (out_valid) begin
        active = 1'b1;
        if (remap_queue.size() == 0) begin
          $error("result with no request outstanding: %p", out_data);
          mismatches++;
        end else begin
          want = remap_queue.pop_front();
          checked_results++;
          if (want.in_range) inside_results++;
          if (out_data.dest_x !== want.dest_x) begin
            $error("dest_x: expected %0d, got %0d", want.dest_x, out_data.dest_x);
            mismatches++;
          end
          if (out_data.dest_y !== want.dest_y) begin
            $error("dest_y: expected %0d, got %0d", want.dest_y, out_data.dest_y);
            mismatches++;
          end
          if (out_data.pixel_out !== want.pixel_out) begin
            $error("pixel_out: expected %0d, got %0d", want.pixel_out, out_data.pixel_out);
            mismatches++;
          end
          if (out_data.in_range !== want.in_range) begin
            $error("in_range: expected %0d, got %0d", want.in_range, out_data.in_range);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        active = 1'b1;
        remap_queue.push_back(want_typed ? want_item : remap_pixel(lens_model, in_data));
      end
      if (cfg_we) begin
        active = 1'b1;
        lens_model = lens_write(lens_model, cfg_reg_t'(cfg_idx), cfg_data);
      end
    end
    idle_cycles <= active ? 0 : idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("lens_distortion_pixel_remap_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    probe_t   rows[$];
    cfg_t     lens_set[7];
    cfg_t     lens;
    in_item_t px;
    int       cur_lens;
    int       vx, vy;
    bit       no_idle;

    lens_set[0] = CFG_RESET;
    lens_set[1] = lens_of(8191, 4096, 0, 0, 0, 0, 0, 0);
    lens_set[2] = lens_of(0, 4096, 0, 0, 0, 0, 0, 0);
    // p2 at its most negative puts (0,16) exactly half a pixel left of column 0.
    lens_set[3] = lens_of(640, 480, 0, 0, 0, 0, 0, 32'h8000_0000);
    lens_set[4] = lens_of(4096, 4096, 2048, 2048, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h7fff_ffff, 32'h7fff_ffff);
    lens_set[5] = lens_of(4096, 4096, 4095, 4095, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000);
    lens_set[6] = lens_of(1920, 1080, 960, 540, -32'sd16384, 32'sd3,
                          32'sd900, -32'sd1200);

    // Reset lens is the identity map on a 640x480 image.
    rows.push_back(probe(0, 0, 0, 8'h00, 1, 0, 0, 1));
    rows.push_back(probe(0, 639, 479, 8'hff, 1, 639, 479, 1));
    rows.push_back(probe(0, 640, 0, 8'h5a, 1, 0, 0, 0));
    rows.push_back(probe(0, 0, 480, 8'ha5, 1, 0, 0, 0));
    rows.push_back(probe(0, 4095, 4095, 8'h3c, 1, 0, 0, 0));
    rows.push_back(probe(0, 320, 240, 8'h81, 1, 320, 240, 1));
    rows.push_back(probe(1, 4095, 4095, 8'hff, 1, 4095, 4095, 1));
    rows.push_back(probe(1, 0, 0, 8'h00, 1, 0, 0, 1));
    rows.push_back(probe(1, 2730, 1365, 8'h55, 1, 2730, 1365, 1));
    rows.push_back(probe(2, 0, 0, 8'h12, 1, 0, 0, 0));
    rows.push_back(probe(2, 5, 7, 8'h34, 1, 0, 0, 0));
    rows.push_back(probe(3, 0, 16, 8'h77, 1, 0, 16, 1));
    rows.push_back(probe(3, 0, 0, 8'h66, 1, 0, 0, 1));
    rows.push_back(probe(3, 1, 16, 8'h99, 0, 0, 0, 0));
    rows.push_back(probe(4, 2048, 2048, 8'hc3, 1, 2048, 2048, 1));
    rows.push_back(probe(4, 0, 0, 8'h01, 0, 0, 0, 0));
    rows.push_back(probe(4, 4095, 4095, 8'hfe, 0, 0, 0, 0));
    rows.push_back(probe(4, 2049, 2048, 8'h10, 0, 0, 0, 0));
    rows.push_back(probe(5, 4095, 4095, 8'h7f, 1, 4095, 4095, 1));
    rows.push_back(probe(5, 0, 0, 8'h80, 0, 0, 0, 0));
    rows.push_back(probe(5, 4095, 0, 8'h20, 0, 0, 0, 0));
    rows.push_back(probe(6, 100, 3000, 8'h44, 0, 0, 0, 0));
    rows.push_back(probe(6, 3000, 100, 8'hbb, 0, 0, 0, 0));
    rows.push_back(probe(6, 2048, 2047, 8'h0f, 0, 0, 0, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur_lens = 0;
    foreach (rows[i]) begin
      if (rows[i].lens != cur_lens) begin
        drain();
        load_lens(lens_set[rows[i].lens]);
        cur_lens = rows[i].lens;
      end
      send_pixel(rows[i].px, rows[i].typed, rows[i].want);
      idle_after(pick_gap(1'b0));
    end

    no_idle = 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      lens = lens_of(rand_dim(), rand_dim(), $urandom_range(0, 4095), $urandom_range(0, 4095),
                     rand_coef(), rand_coef(), rand_coef(), rand_coef());
      load_lens(lens);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
        // Let the pipeline run dry once per setting before carrying on.
        if (n == PHASE_LEN / 2) drain();
        if ($urandom_range(0, 1) == 1) begin
          vx = int'(lens.center_x) + int'($urandom_range(0, 128)) - 64;
          vy = int'(lens.center_y) + int'($urandom_range(0, 128)) - 64;
          vx = (vx < 0) ? 0 : (vx > 4095) ? 4095 : vx;
          vy = (vy < 0) ? 0 : (vy > 4095) ? 4095 : vy;
        end else begin
          vx = $urandom_range(0, 4095);
          vy = $urandom_range(0, 4095);
        end
        px.src_x       = COORD_W'(vx);
        px.src_y       = COORD_W'(vy);
        px.pixel_value = PIX_W'($urandom_range(0, 255));
        send_pixel(px, 1'b0, '0);
        idle_after(pick_gap(no_idle));
      end
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk);
    if (remap_queue.size() != 0) begin
      $error("%0d remapped pixels never came out", remap_queue.size());
      mismatches += remap_queue.size();
    end
    $display("Checked %0d remapped pixels over %0d lens settings loaded after reset;",
             checked_results, settings_loaded);
    $display("%0d of them landed inside the image, %0d field mismatches.",
             inside_results, mismatches);
    if (mismatches == 0) begin
      $display("lens_distortion_pixel_remap_top regression: pass");
    end else begin
      $display("lens_distortion_pixel_remap_top regression: fail");
    end
    $finish;
  end

endmodule

/* lens_distortion_pixel_remap_top.f */
hdl/ldr_pkg.sv
hdl/ldr_front.sv
hdl/ldr_mult.sv
hdl/ldr_acc.sv
hdl/lens_distortion_pixel_remap_top.sv
verif/lens_distortion_pixel_remap_top_tb.sv
